/* rtl/core/fixed_point_q24_8_alu_assert.svh */
// ----------------------------------------------------------------------------
// fixed-point alu assertion macros
// concurrent check wrappers, empty when SYNTH is defined
// ----------------------------------------------------------------------------
`ifndef FIXED_POINT_Q24_8_ALU_ASSERT_SVH
`define FIXED_POINT_Q24_8_ALU_ASSERT_SVH
`ifndef SYNTH
// same-cycle implication
`define FPA_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("fpa check failed");
// next-cycle implication
`define FPA_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("fpa check failed");
`else
`define FPA_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons)
`define FPA_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

/* rtl/core/fpa_pkg.sv */
// ----------------------------------------------------------------------------
// fpa_pkg
// shared constants, opcodes and pipeline types of the fixed-point alu
// ----------------------------------------------------------------------------
`default_nettype none
package fpa_pkg;
    localparam int DATA_WIDTH = 32;
    localparam int FRAC_BITS  = 8;
    localparam int OP_WIDTH   = 4;
    localparam int DIV_BITS   = DATA_WIDTH + FRAC_BITS;
    localparam int PROD_WIDTH = 2 * DATA_WIDTH;

    localparam logic [OP_WIDTH-1:0] OP_ADD  = 4'd0;
    localparam logic [OP_WIDTH-1:0] OP_SUB  = 4'd1;
    localparam logic [OP_WIDTH-1:0] OP_MUL  = 4'd2;
    localparam logic [OP_WIDTH-1:0] OP_DIV  = 4'd3;
    localparam logic [OP_WIDTH-1:0] OP_GT   = 4'd4;
    localparam logic [OP_WIDTH-1:0] OP_LT   = 4'd5;
    localparam logic [OP_WIDTH-1:0] OP_GE   = 4'd6;
    localparam logic [OP_WIDTH-1:0] OP_LE   = 4'd7;
    localparam logic [OP_WIDTH-1:0] OP_EQ   = 4'd8;
    localparam logic [OP_WIDTH-1:0] OP_NE   = 4'd9;
    localparam logic [OP_WIDTH-1:0] OP_MIN  = 4'd10;
    localparam logic [OP_WIDTH-1:0] OP_MAX  = 4'd11;
    localparam logic [OP_WIDTH-1:0] OP_INC  = 4'd12;
    localparam logic [OP_WIDTH-1:0] OP_DEC  = 4'd13;
    localparam logic [OP_WIDTH-1:0] OP_FROM = 4'd14;
    localparam logic [OP_WIDTH-1:0] OP_TOI  = 4'd15;

    // payload that rides alongside the divider
    typedef struct packed {
        logic [OP_WIDTH-1:0]   op;
        logic [DATA_WIDTH-1:0] res;
        logic                  cmp;
        logic                  dz;
        logic                  neg;
    } side_t;
endpackage
`default_nettype wire

/* rtl/core/fpa_if.sv */
// ----------------------------------------------------------------------------
// fpa channel interfaces
// request and response channels with valid/ready handshake
// ----------------------------------------------------------------------------
`default_nettype none
interface fpa_req_if;
    logic                                 valid;
    logic                                 ready;
    logic [fpa_pkg::OP_WIDTH-1:0]         opcode;
    logic signed [fpa_pkg::DATA_WIDTH-1:0] operand_a;
    logic signed [fpa_pkg::DATA_WIDTH-1:0] operand_b;
    modport source (output valid, opcode, operand_a, operand_b, input ready);
    modport sink   (input valid, opcode, operand_a, operand_b, output ready);
endinterface

interface fpa_rsp_if;
    logic                                 valid;
    logic                                 ready;
    logic signed [fpa_pkg::DATA_WIDTH-1:0] result_value;
    logic                                 compare_true;
    logic                                 divide_by_zero;
    modport source (output valid, result_value, compare_true, divide_by_zero, input ready);
    modport sink   (input valid, result_value, compare_true, divide_by_zero, output ready);
endinterface
`default_nettype wire

/* rtl/core/fpa_div.sv */
// ----------------------------------------------------------------------------
// fpa_div
// unsigned restoring divider, one quotient bit per pipeline stage
// ----------------------------------------------------------------------------
`default_nettype none
module fpa_div (
    input  logic                              clk,
    input  logic                              en,
    input  logic [fpa_pkg::DIV_BITS-1:0]      dividend,
    input  logic [fpa_pkg::DATA_WIDTH-1:0]    divisor,
    output logic [fpa_pkg::DIV_BITS-1:0]      quotient
);
    localparam int DW = fpa_pkg::DATA_WIDTH;
    localparam int NB = fpa_pkg::DIV_BITS;

    logic [DW-1:0] rem_reg [NB];
    logic [NB-1:0] quo_reg [NB];
    logic [DW-1:0] dvs_reg [NB];

    for (genvar k = 0; k < NB; k++) begin : g_stage
        logic [DW-1:0] rem_in;
        logic [NB-1:0] quo_in;
        logic [DW-1:0] dvs_in;
        logic [DW:0]   trial;
        logic [DW:0]   diff;
        logic [DW-1:0] rem_next;
        logic [NB-1:0] quo_next;

        if (k == 0) begin : g_first
            assign rem_in = '0;
            assign quo_in = dividend;
            assign dvs_in = divisor;
        end
        else begin : g_rest
            assign rem_in = rem_reg[k-1];
            assign quo_in = quo_reg[k-1];
            assign dvs_in = dvs_reg[k-1];
        end

        always_comb
        begin
            trial = {rem_in, quo_in[NB-1]};
            diff  = trial - {1'b0, dvs_in};
            if (!diff[DW])
            begin
                rem_next = diff[DW-1:0];
                quo_next = {quo_in[NB-2:0], 1'b1};
            end
            else
            begin
                rem_next = trial[DW-1:0];
                quo_next = {quo_in[NB-2:0], 1'b0};
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[k] <= rem_next;
                quo_reg[k] <= quo_next;
                dvs_reg[k] <= dvs_in;
            end
        end
    end

    assign quotient = quo_reg[NB-1];
endmodule
`default_nettype wire

/* rtl/core/fixed_point_q24_8_alu.sv */
// ----------------------------------------------------------------------------
// fixed_point_q24_8_alu
// pipelined signed q24.8 alu: arithmetic, compare, min/max and conversions
// ----------------------------------------------------------------------------
//   channel  dir  payload                                        handshake
//   req      in   opcode, operand_a, operand_b                   valid/ready
//   rsp      out  result_value, compare_true, divide_by_zero     valid/ready
//
// one transaction enters per cycle while the pipe advances; each result is offered
// on rsp after its request passes the input register (loaded at the accepting edge),
// 40 divider stages at one quotient bit each, and the output register
// every opcode runs the full depth so results leave in order
// the whole pipe advances when the output register is empty or being taken
// a stall freezes every stage in place; reset clears only the valid bits
// ----------------------------------------------------------------------------
`default_nettype none
`include "fixed_point_q24_8_alu_assert.svh"
module fixed_point_q24_8_alu (
    input  logic       clk,
    input  logic       rst_n,
    fpa_req_if.sink    req,
    fpa_rsp_if.source  rsp
);
    localparam int DW = fpa_pkg::DATA_WIDTH;
    localparam int FB = fpa_pkg::FRAC_BITS;
    localparam int NB = fpa_pkg::DIV_BITS;
    localparam int PW = fpa_pkg::PROD_WIDTH;

    // global advance: output slot free or draining this cycle
    logic adv;

    // input stage
    logic                         s1_valid_reg;
    logic [fpa_pkg::OP_WIDTH-1:0] s1_op_reg;
    logic signed [DW-1:0]         s1_a_reg;
    logic signed [DW-1:0]         s1_b_reg;

    // side line matched to divider depth
    logic [NB-1:0]   side_valid_reg;
    fpa_pkg::side_t  side_reg [NB];
    fpa_pkg::side_t  side_next;

    // output stage
    logic                         rsp_valid_reg;
    logic [fpa_pkg::OP_WIDTH-1:0] rsp_op_reg;
    logic signed [DW-1:0]         rsp_res_reg;
    logic                         rsp_cmp_reg;
    logic                         rsp_dz_reg;
    logic signed [DW-1:0]         rsp_res_next;

    // stage-one datapath
    logic signed [PW-1:0] prod;
    logic [DW-1:0]        mag_a;
    logic [DW-1:0]        mag_b;
    logic [NB-1:0]        dividend;
    logic [NB-1:0]        quotient;
    logic [DW-1:0]        q_low;
    logic                 a_gt_b;
    logic                 b_gt_a;

    // output-side properties
    logic                 rsp_dz_ok;
    logic                 rsp_cmp_ok;

    assign adv       = !rsp_valid_reg || rsp.ready;
    assign req.ready = adv;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            s1_valid_reg <= req.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s1_op_reg <= req.opcode;
            s1_a_reg  <= req.operand_a;
            s1_b_reg  <= req.operand_b;
        end
    end

    // magnitudes fit in dw unsigned bits, most negative included
    assign mag_a    = s1_a_reg[DW-1] ? DW'(-s1_a_reg) : DW'(s1_a_reg);
    assign mag_b    = s1_b_reg[DW-1] ? DW'(-s1_b_reg) : DW'(s1_b_reg);
    assign dividend = {mag_a, {FB{1'b0}}};
    assign prod     = PW'(s1_a_reg) * PW'(s1_b_reg);
    assign a_gt_b   = s1_a_reg > s1_b_reg;
    assign b_gt_a   = s1_b_reg > s1_a_reg;

    always_comb
    begin
        side_next     = '0;
        side_next.op  = s1_op_reg;
        side_next.neg = s1_a_reg[DW-1] ^ s1_b_reg[DW-1];
        case (s1_op_reg)
            fpa_pkg::OP_ADD:  side_next.res = s1_a_reg + s1_b_reg;
            fpa_pkg::OP_SUB:  side_next.res = s1_a_reg - s1_b_reg;
            // signed product equals the sign-fixed magnitude product
            fpa_pkg::OP_MUL:  side_next.res = prod[DW+FB-1:FB];
            fpa_pkg::OP_DIV:  side_next.dz  = (s1_b_reg == '0);
            fpa_pkg::OP_GT:   side_next.cmp = a_gt_b;
            fpa_pkg::OP_LT:   side_next.cmp = b_gt_a;
            fpa_pkg::OP_GE:   side_next.cmp = !b_gt_a;
            fpa_pkg::OP_LE:   side_next.cmp = !a_gt_b;
            fpa_pkg::OP_EQ:   side_next.cmp = (s1_a_reg == s1_b_reg);
            fpa_pkg::OP_NE:   side_next.cmp = (s1_a_reg != s1_b_reg);
            fpa_pkg::OP_MIN:  side_next.res = a_gt_b ? s1_b_reg : s1_a_reg;
            fpa_pkg::OP_MAX:  side_next.res = a_gt_b ? s1_a_reg : s1_b_reg;
            fpa_pkg::OP_INC:  side_next.res = s1_a_reg + DW'(1);
            fpa_pkg::OP_DEC:  side_next.res = s1_a_reg - DW'(1);
            fpa_pkg::OP_FROM: side_next.res = s1_a_reg << FB;
            default:          side_next.res = s1_a_reg >>> FB;
        endcase
    end

    // quotient magnitude, one bit per stage
    fpa_div u_div (
        .clk      (clk),
        .en       (adv),
        .dividend (dividend),
        .divisor  (mag_b),
        .quotient (quotient)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            side_valid_reg <= '0;
        end
        else if (adv)
        begin
            side_valid_reg <= {side_valid_reg[NB-2:0], s1_valid_reg};
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            side_reg[0] <= side_next;
            for (int k = 1; k < NB; k++)
            begin
                side_reg[k] <= side_reg[k-1];
            end
        end
    end

    // final select: signed quotient wraps to the low word
    assign q_low = quotient[DW-1:0];

    always_comb
    begin
        if (side_reg[NB-1].op == fpa_pkg::OP_DIV)
        begin
            if (side_reg[NB-1].dz)
            begin
                rsp_res_next = '0;
            end
            else
            begin
                rsp_res_next = side_reg[NB-1].neg ? -q_low : q_low;
            end
        end
        else
        begin
            rsp_res_next = side_reg[NB-1].res;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            rsp_valid_reg <= side_valid_reg[NB-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            rsp_op_reg  <= side_reg[NB-1].op;
            rsp_res_reg <= rsp_res_next;
            rsp_cmp_reg <= side_reg[NB-1].cmp;
            rsp_dz_reg  <= side_reg[NB-1].dz;
        end
    end

    assign rsp.valid          = rsp_valid_reg;
    assign rsp.result_value   = rsp_res_reg;
    assign rsp.compare_true   = rsp_cmp_reg;
    assign rsp.divide_by_zero = rsp_dz_reg;

    assign rsp_dz_ok  = (rsp_res_reg == '0) && (rsp_op_reg == fpa_pkg::OP_DIV);
    assign rsp_cmp_ok = (rsp_res_reg == '0)
                     && (rsp_op_reg inside {fpa_pkg::OP_GT, fpa_pkg::OP_LT, fpa_pkg::OP_GE,
                                            fpa_pkg::OP_LE, fpa_pkg::OP_EQ, fpa_pkg::OP_NE});

    // divide-by-zero only on divide, and it forces a zero result
    `FPA_ASSERT_IMPLY(a_dz_zero, clk, rst_n, rsp_valid_reg && rsp_dz_reg, rsp_dz_ok)
    // compare flag only for the six compare opcodes, with zero value
    `FPA_ASSERT_IMPLY(a_cmp_op, clk, rst_n, rsp_valid_reg && rsp_cmp_reg, rsp_cmp_ok)
    // a stalled pipe keeps its side-line valid bits in place and its output valid
    `FPA_ASSERT_NEXT(a_stall_hold, clk, rst_n, !adv, $stable(side_valid_reg) && rsp_valid_reg)
    // a transaction in the input stage reaches the side line on advance
    `FPA_ASSERT_NEXT(a_s1_move, clk, rst_n, adv && s1_valid_reg, side_valid_reg[0])
endmodule
`default_nettype wire

/* verif/fixed_point_q24_8_alu_checker.sv */
// ----------------------------------------------------------------------------
// fixed-point alu result checker
// predicts each result from the accepted request and compares it in order
// ----------------------------------------------------------------------------
module fixed_point_q24_8_alu_checker (
    input  logic clk,
    input  logic rst_n,
    fpa_req_if   req,
    fpa_rsp_if   rsp,
    output int   fail_count,
    output int   pending
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic signed [fpa_pkg::DATA_WIDTH-1:0] value;
        logic                                  cmp;
        logic                                  dz;
    } alu_result_t;

    alu_result_t expected_results[$];

    function automatic alu_result_t compute_alu(logic [fpa_pkg::OP_WIDTH-1:0] op,
                                                logic signed [31:0] a,
                                                logic signed [31:0] b);
        alu_result_t r;
        logic signed [63:0] wa, wb, prod, quot;
        logic [63:0] ma, mb;
        r = '0;
        wa = 64'(a);
        wb = 64'(b);
        case (op)
            fpa_pkg::OP_ADD:  r.value = a + b;
            fpa_pkg::OP_SUB:  r.value = a - b;
            fpa_pkg::OP_MUL:
            begin
                prod = (wa * wb) >>> fpa_pkg::FRAC_BITS;
                r.value = prod[31:0];
            end
            fpa_pkg::OP_DIV:
            begin
                if (b == 0)
                    r.dz = 1'b1;
                else
                begin
                    ma = wa < 0 ? -wa : wa;
                    mb = wb < 0 ? -wb : wb;
                    quot = (ma << fpa_pkg::FRAC_BITS) / mb;
                    if ((a < 0) != (b < 0))
                        quot = -quot;
                    r.value = quot[31:0];
                end
            end
            fpa_pkg::OP_GT:   r.cmp = a > b;
            fpa_pkg::OP_LT:   r.cmp = a < b;
            fpa_pkg::OP_GE:   r.cmp = a >= b;
            fpa_pkg::OP_LE:   r.cmp = a <= b;
            fpa_pkg::OP_EQ:   r.cmp = a == b;
            fpa_pkg::OP_NE:   r.cmp = a != b;
            fpa_pkg::OP_MIN:  r.value = a > b ? b : a;
            fpa_pkg::OP_MAX:  r.value = a > b ? a : b;
            fpa_pkg::OP_INC:  r.value = a + 1;
            fpa_pkg::OP_DEC:  r.value = a - 1;
            fpa_pkg::OP_FROM: r.value = a <<< fpa_pkg::FRAC_BITS;
            default:          r.value = a >>> fpa_pkg::FRAC_BITS;
        endcase
        return r;
    endfunction

    always @(posedge clk)
    begin
        alu_result_t exp_r;
        if (rst_n)
        begin
            if (req.valid && req.ready)
                expected_results.push_back(compute_alu(req.opcode, req.operand_a,
                                                       req.operand_b));
            if (rsp.valid && rsp.ready)
            begin
                if (expected_results.size() == 0)
                begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display("unexpected result transaction %h",
                                 rsp.result_value);
                end
                else
                begin
                    exp_r = expected_results.pop_front();
                    if (exp_r.value !== rsp.result_value || exp_r.cmp !== rsp.compare_true
                        || exp_r.dz !== rsp.divide_by_zero)
                    begin
                        fail_count++;
                        if (fail_count <= 10)
                            $display("mismatch: expected %h/%b/%b got %h/%b/%b",
                                     exp_r.value, exp_r.cmp, exp_r.dz, rsp.result_value,
                                     rsp.compare_true, rsp.divide_by_zero);
                    end
                end
            end
        end
        pending = expected_results.size();
    end
endmodule

/* verif/fixed_point_q24_8_alu_tb.sv */
// ----------------------------------------------------------------------------
// fixed-point alu testbench
// directed corner operands then random opcodes with random stalls on both
// sides; the checker scores every result against its own prediction
// ----------------------------------------------------------------------------
module fixed_point_q24_8_alu_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int OPW          = fpa_pkg::OP_WIDTH;
    localparam int RANDOM_ITEMS = 1100;
    localparam int CALM_ITEMS   = 150;    // tail of the run without idling
    localparam int PIPE_DEPTH   = 42;
    localparam int IDLE_LIMIT   = 2000;   // cycles with no transaction at all

    logic clk;
    logic rst_n;
    int   fail_count;
    int   pending;
    int   idle_cycles;
    bit   calm;

    fpa_req_if req ();
    fpa_rsp_if rsp ();

    fixed_point_q24_8_alu uut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req.sink),
        .rsp   (rsp.source)
    );

    fixed_point_q24_8_alu_checker checker_i (
        .clk        (clk),
        .rst_n      (rst_n),
        .req        (req),
        .rsp        (rsp),
        .fail_count (fail_count),
        .pending    (pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // corner operand values: extremes, zero, +/- one lsb, +/- one in q24.8, else random
    function automatic logic [31:0] corner_operand();
        case ($urandom_range(0, 7))
            0: return 32'h8000_0000;
            1: return 32'h7fff_ffff;
            2: return 32'h0000_0000;
            3: return 32'hffff_ffff;
            4: return 32'h0000_0001;
            5: return 32'h0000_0100;
            6: return 32'hffff_ff00;
            default: return $urandom;
        endcase
    endfunction

    // push one request transaction, holding it until accepted
    task automatic send_request(logic [OPW-1:0] op, logic [31:0] a, logic [31:0] b);
        int gap;
        if (!calm && $urandom_range(0, 3) == 0)
        begin
            gap = $urandom_range(1, 11);
            req.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req.valid     <= 1'b1;
        req.opcode    <= op;
        req.operand_a <= a;
        req.operand_b <= b;
        @(posedge clk);
        while (!req.ready)
            @(posedge clk);
    endtask

    // response side: random stall bursts, none in the calm phase
    initial
    begin
        int burst;
        rsp.ready <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (burst > 0 && !calm)
            begin
                burst--;
                rsp.ready <= 1'b0;
            end
            else if (!calm && $urandom_range(0, 5) == 0)
            begin
                // stall starts now; burst holds the remaining stalled cycles
                burst = $urandom_range(0, 10);
                rsp.ready <= 1'b0;
            end
            else
                rsp.ready <= 1'b1;
        end
    end

    // watchdog on cycles without any accepted transaction
    always @(posedge clk)
    begin
        if ((req.valid && req.ready) || (rsp.valid && rsp.ready) || !rst_n)
            idle_cycles <= 0;
        else if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("simulation failed");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    initial
    begin
        logic [OPW-1:0] op;
        calm = 1'b0;
        rst_n = 1'b0;
        req.valid     <= 1'b0;
        req.opcode    <= fpa_pkg::OP_ADD;
        req.operand_a <= '0;
        req.operand_b <= '0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: every opcode on corner pairs, plus wrap and divide cases
        for (int o = 0; o < 16; o++)
            send_request(o[OPW-1:0], 32'h8000_0000, 32'h7fff_ffff);
        send_request(fpa_pkg::OP_DIV, 32'h8000_0000, 32'hffff_ffff);   // most negative / -1
        send_request(fpa_pkg::OP_DIV, 32'h1234_5678, 32'h0);           // divide by zero
        send_request(fpa_pkg::OP_MUL, 32'h8000_0000, 32'h8000_0000);
        send_request(fpa_pkg::OP_MIN, 32'h0000_0100, 32'h0000_0100);   // equal operands
        send_request(fpa_pkg::OP_MAX, 32'hffff_ff00, 32'hffff_ff00);
        send_request(fpa_pkg::OP_TOI, 32'hffff_ff01, 32'h0);      // rounds toward minus inf
        send_request(fpa_pkg::OP_EQ, 32'hffff_ffff, 32'hffff_ffff);
        send_request(fpa_pkg::OP_INC, 32'h7fff_ffff, 32'h0);

        for (int i = 0; i < RANDOM_ITEMS; i++)
        begin
            if (i == RANDOM_ITEMS - CALM_ITEMS)
                calm = 1'b1;
            op = OPW'($urandom_range(0, 15));
            if ($urandom_range(0, 3) == 0)
                send_request(op, corner_operand(), corner_operand());
            else if (op == fpa_pkg::OP_DIV && $urandom_range(0, 1) == 0)
                // small divisors keep the quotient in range more often
                send_request(op, $urandom, $urandom_range(0, 32'h0000_ffff) ^
                             ({32{$urandom_range(0, 1) == 1}}));
            else
                send_request(op, $urandom, $urandom);
        end
        req.valid <= 1'b0;

        while (pending != 0)
            @(posedge clk);
        repeat (PIPE_DEPTH + 10) @(posedge clk);

        if (fail_count == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end
endmodule
